/* hdl/vp256_pkg.sv */
// Shared constants and types for the vertical parity engine.
// No dependencies; imported by vp256_accum, vp256_resq and the top level.
package vp256_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int LANE_W      = 8;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int NWORDS      = (BLOCK_BYTES + 7) / 8;
  localparam int WORD_W      = 64;
  localparam int PAR_W       = NWORDS * WORD_W;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  localparam int IN_FIELDS_W  = LANE_W + WORD_W + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = WORD_W + IDX_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PARITY  = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef logic [LANE_W-1:0] lane_t;

  // Result burst handed from the accumulator to the result sequencer.
  typedef struct packed {
    kind_t             kind;
    logic              good;
    logic [PAR_W-1:0]  parity;
  } burst_req_t;

endpackage

/* hdl/vp256_accum.sv */
// Input register, column lane accumulator and parity compare.
// Depends on vp256_pkg; feeds burst requests to vp256_resq.
module vp256_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vp256_pkg::op_t             in_op,
  input  logic [7:0]                 in_byte,
  input  logic [63:0]                in_expected,
  input  logic [vp256_pkg::IDX_W-1:0] in_widx,
  input  logic                       in_last,
  output logic                       req_valid,
  input  logic                       req_ready,
  output vp256_pkg::burst_req_t      req
);
  import vp256_pkg::*;

  logic             s1_valid_r;
  op_t              s1_op_r;
  lane_t            s1_byte_r;
  logic [WORD_W-1:0] s1_exp_r;
  logic [IDX_W-1:0] s1_widx_r;
  logic             s1_last_r;

  lane_t            acc_r   [BLOCK_BYTES];
  lane_t            acc_nxt [BLOCK_BYTES];
  lane_t            lanes_upd [BLOCK_BYTES];
  logic [POS_W-1:0] pos_r, pos_nxt, pos_base;
  logic             closed_r, closed_nxt;
  logic             mis_r, mis_nxt;

  logic [PAR_W-1:0]  par_cur, par_upd;
  logic [WORD_W-1:0] par_sel;
  logic              mism;
  logic              produces;
  logic              adv;

  // Odd parity: a column bit is set when its lane holds an even count of ones.
  // Lanes past the block read as all ones.
  always_comb begin
    for (int i = 0; i < NWORDS * 8; i++) begin
      if (i < BLOCK_BYTES) begin
        par_cur[i*LANE_W +: LANE_W] = ~acc_r[i];
        par_upd[i*LANE_W +: LANE_W] = ~lanes_upd[i];
      end else begin
        par_cur[i*LANE_W +: LANE_W] = '1;
        par_upd[i*LANE_W +: LANE_W] = '1;
      end
    end
  end

  assign par_sel  = par_cur[s1_widx_r*WORD_W +: WORD_W];
  assign mism     = (par_sel != s1_exp_r);
  assign pos_base = closed_r ? '0 : pos_r;

  // A data byte after close starts a fresh buffer.
  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      lanes_upd[i] = closed_r ? '0 : acc_r[i];
    end
    lanes_upd[pos_base] = lanes_upd[pos_base] ^ s1_byte_r;
  end

  assign produces  = s1_valid_r && s1_last_r && ((s1_op_r == OP_DATA) || closed_r);
  assign adv       = s1_valid_r && (!produces || req_ready);
  // Hold off requests while reset is applied.
  assign in_ready  = rst_n && (!s1_valid_r || adv);
  assign req_valid = s1_valid_r && produces;

  always_comb begin
    req.kind   = (s1_op_r == OP_DATA) ? KIND_PARITY : KIND_VERDICT;
    req.good   = !(mis_r || mism);
    req.parity = par_upd;
  end

  always_comb begin
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    closed_nxt = closed_r;
    mis_nxt    = mis_r;
    if (adv) begin
      if (s1_op_r == OP_DATA) begin
        acc_nxt    = lanes_upd;
        pos_nxt    = (pos_base == POS_W'(BLOCK_BYTES - 1)) ? '0 : pos_base + 1'b1;
        closed_nxt = s1_last_r;
        mis_nxt    = 1'b0;
      end else if (closed_r) begin
        mis_nxt = s1_last_r ? 1'b0 : (mis_r || mism);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      closed_r   <= 1'b0;
      mis_r      <= 1'b0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      pos_r    <= pos_nxt;
      closed_r <= closed_nxt;
      mis_r    <= mis_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_byte;
      s1_exp_r  <= in_expected;
      s1_widx_r <= in_widx;
      s1_last_r <= in_last;
    end
  end

  a_no_check_open: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && s1_op_r == OP_CHECK) |-> closed_r)
    else $error("verdict requested on an open buffer");

  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_DATA && s1_last_r) |=> closed_r)
    else $error("buffer not closed after last data byte");

  a_data_clears_mis: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_DATA) |=> !mis_r)
    else $error("mismatch flag survived a data byte");

endmodule

/* hdl/vp256_resq.sv */
// Result sequencer: holds one burst and plays it out a word per accepted output transfer.
// Depends on vp256_pkg; loaded from vp256_accum.
module vp256_resq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  vp256_pkg::burst_req_t req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vp256_pkg::kind_t      out_kind,
  output logic [63:0]           out_parity,
  output logic [vp256_pkg::IDX_W-1:0] out_index,
  output logic                  out_good,
  output logic                  out_last
);
  import vp256_pkg::*;

  logic             ob_valid_r, ob_valid_nxt;
  kind_t            ob_kind_r;
  logic             ob_good_r;
  logic [PAR_W-1:0] ob_par_r;
  logic [CNT_W-1:0] ob_cnt_r, ob_cnt_nxt;
  logic             ob_last;
  logic             load;
  logic             take;

  assign ob_last   = (ob_kind_r == KIND_VERDICT) || (ob_cnt_r == CNT_W'(NWORDS - 1));
  assign take      = ob_valid_r && out_ready;
  assign req_ready = !ob_valid_r || (out_ready && ob_last);
  assign load      = req_valid && req_ready;

  always_comb begin
    ob_valid_nxt = ob_valid_r;
    ob_cnt_nxt   = ob_cnt_r;
    if (load) begin
      ob_valid_nxt = 1'b1;
      ob_cnt_nxt   = '0;
    end else if (take) begin
      if (ob_last) begin
        ob_valid_nxt = 1'b0;
      end else begin
        ob_cnt_nxt = ob_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_cnt_r   <= '0;
    end else begin
      ob_valid_r <= ob_valid_nxt;
      ob_cnt_r   <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_kind_r <= req.kind;
      ob_good_r <= req.good;
      ob_par_r  <= req.parity;
    end
  end

  always_comb begin
    out_valid = ob_valid_r;
    out_kind  = ob_kind_r;
    out_last  = ob_last;
    if (ob_kind_r == KIND_VERDICT) begin
      out_parity = '0;
      out_index  = '0;
      out_good   = ob_good_r;
    end else begin
      out_parity = ob_par_r[ob_cnt_r*WORD_W +: WORD_W];
      out_index  = IDX_W'(ob_cnt_r);
      out_good   = 1'b0;
    end
  end

  a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !ob_last) |=> (ob_valid_r && ob_cnt_r == CNT_W'($past(ob_cnt_r) + 1'b1)))
    else $error("parity word counter skipped");

  a_verdict_single: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_valid_r && ob_kind_r == KIND_VERDICT) |-> (ob_cnt_r == '0))
    else $error("verdict with nonzero word count");

endmodule

/* hdl/vertical_parity_256_engine_core.sv */
// Top level of the vertical parity engine: odd column parity over 256-bit words.
// Depends on vp256_pkg, vp256_accum and vp256_resq.
//
// Usage:
//   The in_ channel carries one request per cycle when ready. in_tuser = 0
//   is a buffer byte, in_tuser = 1 an expected parity word; in_tlast marks
//   the last byte of a buffer or the last expected word of a check round.
//   The last byte of a buffer yields four parity words on the out_ channel,
//   word index 0..3, with out_tlast on the fourth. The last expected word of a
//   round yields one verdict (out_tuser = 1) with check_good in out_tdata.
//   A request is registered on acceptance; one that yields results then loads
//   the result sequencer, which offers them from its own register. Bytes and
//   non-final checks are taken one per cycle unless a result-producing
//   request waits in the input register. A burst of four words holds the
//   output until its last word is taken; the input keeps taking requests
//   until another burst-producing request meets a busy result sequencer,
//   then stalls until the last word goes. When the receiver drops out_tready
//   the current result holds; bytes and non-final checks still flow until a
//   result-producing request backs up. Reset clears lanes, position, the
//   closed and mismatch flags; no request is taken while rst_n is low.
module vertical_parity_256_engine_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] data_byte, [71:8] expected_word, [73:72] word_index, rest zero
  input  logic [vp256_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] parity_out, [65:64] out_index, [66] check_good, rest zero
  output logic [vp256_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] result_kind
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import vp256_pkg::*;

  logic              req_valid;
  logic              req_ready;
  burst_req_t        req;
  op_t               in_op;
  kind_t             res_kind;
  logic [WORD_W-1:0] res_parity;
  logic [IDX_W-1:0]  res_index;
  logic              res_good;

  assign in_op = op_t'(in_tuser);

  vp256_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_op),
    .in_byte     (in_tdata[LANE_W-1:0]),
    .in_expected (in_tdata[LANE_W +: WORD_W]),
    .in_widx     (in_tdata[LANE_W+WORD_W +: IDX_W]),
    .in_last     (in_tlast),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req)
  );

  vp256_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (res_kind),
    .out_parity (res_parity),
    .out_index  (res_index),
    .out_good   (res_good),
    .out_last   (out_tlast)
  );

  assign out_tuser = logic'(res_kind);
  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res_good, res_index, res_parity};

endmodule
